### rtl/idwvf_pkg.sv
package idwvf_pkg;

  localparam int unsigned MAX_ANCHORS_DEF = 128;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned VEC_W      = 16;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned SQ_W       = 64;
  localparam int unsigned D2_W       = 34;
  localparam int unsigned DIV_NUM_W  = 43;
  localparam int unsigned W_W        = 39;
  localparam int unsigned DIV_STEPS  = DIV_NUM_W;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned STEP_W     = 6;
  localparam int unsigned FRAC_W     = 12;
  localparam int unsigned NORM_SH    = 30;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_INTERP = 3'd0,
    ST_EXACT  = 3'd1,
    ST_PASS   = 3'd2,
    ST_DEGEN  = 3'd3,
    ST_FULL   = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_CLEAR,
    OP_QINIT,
    OP_RD,
    OP_DIFF,
    OP_SQD,
    OP_WDIV_INIT,
    OP_DIV_STEP,
    OP_MAC,
    OP_NEXT,
    OP_SVEC,
    OP_ABS,
    OP_SHIFT,
    OP_SQN,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_NDIV_INIT,
    OP_NSTORE,
    OP_COPY,
    OP_PASS,
    OP_RES_ZERO,
    OP_WRITE,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD,
    S_DIFF,
    S_SQD,
    S_CHK,
    S_WDIV,
    S_MAC,
    S_NEXT,
    S_ABS,
    S_SHIFT,
    S_SQN,
    S_SQRT0,
    S_SQRT,
    S_NDIV0,
    S_NDIV,
    S_NSTORE,
    S_WRITE,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e      op;
    logic [1:0]  comp;
    status_e     status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       has_vector;
    logic       cnt_zero;
    logic       cnt_full;
    logic       d2_zero;
    logic       idx_last;
    logic       m_zero;
    logic       m_big;
    logic       out_free;
  } dp_stat_t;

endpackage

### rtl/idwvf_in_if.sv
interface idwvf_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] vec_in_x;
  logic signed [15:0] vec_in_y;
  logic signed [15:0] vec_in_z;
  logic              has_vector;

  modport source (
    output valid, kind, pos_x, pos_y, pos_z, vec_in_x, vec_in_y, vec_in_z, has_vector,
    input  ready
  );
  modport sink (
    input  valid, kind, pos_x, pos_y, pos_z, vec_in_x, vec_in_y, vec_in_z, has_vector,
    output ready
  );
endinterface

### rtl/idwvf_out_if.sv
interface idwvf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vec_out_x;
  logic signed [15:0] vec_out_y;
  logic signed [15:0] vec_out_z;
  logic [2:0]         status;

  modport source (
    output valid, vec_out_x, vec_out_y, vec_out_z, status,
    input  ready
  );
  modport sink (
    input  valid, vec_out_x, vec_out_y, vec_out_z, status,
    output ready
  );
endinterface

### rtl/idw_vector_field_interpolator_unit.sv
// Inverse-distance (power 2) vector field interpolator. Transactions of kind load store an
// anchor (position plus Q4.12 vector normalized to unit length); kind clear empties the
// store; kind query returns one result: the query's own vector (has_vector set), the unit
// vector of the first anchor at the same position, or the normalized 1/d^2-weighted sum of
// all anchor vectors, with a degenerate-zero status for an empty store or zero sum. A load
// into a full store returns a zero vector with status full. One transaction is processed
// at a time. A load normalizes its vector like a query's sum (a zero vector is stored as
// zero); a query walks the stored anchors with one 43-step bit-serial divider run per
// anchor for the weight (an exact hit stops the walk), then a normalization pass shifts
// the sum right (at most 27 times), takes a 32-step square root and does three 43-step
// divisions. Clear returns no result; pass-through, full and empty-store results wait
// while the output register is held. A new transaction is accepted while a finished
// result waits in the output register.
module idw_vector_field_interpolator_unit #(
  parameter int unsigned MaxAnchors = idwvf_pkg::MAX_ANCHORS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  idwvf_in_if.sink     in_i,
  idwvf_out_if.source  out_o
);
  import idwvf_pkg::*;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic              in_ready;
  logic [2:0][15:0]  in_pos;
  logic [2:0][15:0]  in_vec;
  logic [2:0][15:0]  out_vec;
  logic              out_valid;
  logic [2:0]        out_status;

  assign in_pos = {in_i.pos_z, in_i.pos_y, in_i.pos_x};
  assign in_vec = {in_i.vec_in_z, in_i.vec_in_y, in_i.vec_in_x};
  assign in_i.ready = in_ready;

  idwvf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  idwvf_dp #(
    .MaxAnchors (MaxAnchors)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .in_kind_i       (in_i.kind),
    .in_pos_i        (in_pos),
    .in_vec_i        (in_vec),
    .in_has_vector_i (in_i.has_vector),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_o.ready),
    .out_vec_o       (out_vec),
    .out_status_o    (out_status)
  );

  assign out_o.valid     = out_valid;
  assign out_o.vec_out_x = out_vec[0];
  assign out_o.vec_out_y = out_vec[1];
  assign out_o.vec_out_z = out_vec[2];
  assign out_o.status    = out_status;

endmodule

### rtl/idwvf_ram.sv
module idwvf_ram #(
  parameter int unsigned Width = 96,
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/idwvf_ctrl.sv
module idwvf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  idwvf_pkg::dp_stat_t stat_i,
  output idwvf_pkg::dp_cmd_t  cmd_o
);
  import idwvf_pkg::*;

  ctrl_state_e       state_q, state_d;
  logic [1:0]        comp_q, comp_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              load_q, load_d;
  status_e           est_q, est_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      comp_q  <= '0;
      step_q  <= '0;
      load_q  <= 1'b0;
      est_q   <= ST_INTERP;
    end else begin
      state_q <= state_d;
      comp_q  <= comp_d;
      step_q  <= step_d;
      load_q  <= load_d;
      est_q   <= est_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    comp_d      = comp_q;
    step_d      = step_q;
    load_d      = load_q;
    est_d       = est_q;
    in_ready_o  = 1'b0;
    cmd_o.op    = OP_NOP;
    cmd_o.comp  = comp_q;
    cmd_o.status = est_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (stat_i.kind == KIND_LOAD) begin
          if (stat_i.cnt_full) begin
            cmd_o.op = OP_RES_ZERO;
            est_d    = ST_FULL;
            state_d  = S_EMIT;
          end else begin
            cmd_o.op = OP_SVEC;
            load_d   = 1'b1;
            state_d  = S_ABS;
          end
        end else if (stat_i.kind == KIND_CLEAR) begin
          cmd_o.op = OP_CLEAR;
          state_d  = S_IDLE;
        end else if (stat_i.kind == KIND_QUERY) begin
          load_d = 1'b0;
          priority if (stat_i.has_vector) begin
            cmd_o.op = OP_PASS;
            est_d    = ST_PASS;
            state_d  = S_EMIT;
          end else if (stat_i.cnt_zero) begin
            cmd_o.op = OP_RES_ZERO;
            est_d    = ST_DEGEN;
            state_d  = S_EMIT;
          end else begin
            cmd_o.op = OP_QINIT;
            state_d  = S_RD;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        cmd_o.op = OP_RD;
        state_d  = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.op = OP_DIFF;
        comp_d   = '0;
        state_d  = S_SQD;
      end
      S_SQD: begin
        cmd_o.op = OP_SQD;
        comp_d   = comp_q + 2'd1;
        if (comp_q == 2'd2) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (stat_i.d2_zero) begin
          cmd_o.op = OP_COPY;
          est_d    = ST_EXACT;
          state_d  = S_EMIT;
        end else begin
          cmd_o.op = OP_WDIV_INIT;
          step_d   = '0;
          state_d  = S_WDIV;
        end
      end
      S_WDIV: begin
        cmd_o.op = OP_DIV_STEP;
        step_d   = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          comp_d  = '0;
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        cmd_o.op = OP_MAC;
        comp_d   = comp_q + 2'd1;
        if (comp_q == 2'd2) begin
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd_o.op = OP_NEXT;
        state_d  = stat_i.idx_last ? S_ABS : S_RD;
      end
      S_ABS: begin
        cmd_o.op = OP_ABS;
        state_d  = S_SHIFT;
      end
      S_SHIFT: begin
        priority if (stat_i.m_zero) begin
          cmd_o.op = OP_RES_ZERO;
          if (load_q) begin
            state_d = S_WRITE;
          end else begin
            est_d   = ST_DEGEN;
            state_d = S_EMIT;
          end
        end else if (stat_i.m_big) begin
          cmd_o.op = OP_SHIFT;
        end else begin
          comp_d  = '0;
          state_d = S_SQN;
        end
      end
      S_SQN: begin
        cmd_o.op = OP_SQN;
        comp_d   = comp_q + 2'd1;
        if (comp_q == 2'd2) begin
          state_d = S_SQRT0;
        end
      end
      S_SQRT0: begin
        cmd_o.op = OP_SQRT_INIT;
        step_d   = '0;
        comp_d   = '0;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        step_d   = step_q + 1'b1;
        if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
          state_d = S_NDIV0;
        end
      end
      S_NDIV0: begin
        cmd_o.op = OP_NDIV_INIT;
        step_d   = '0;
        state_d  = S_NDIV;
      end
      S_NDIV: begin
        cmd_o.op = OP_DIV_STEP;
        step_d   = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = S_NSTORE;
        end
      end
      S_NSTORE: begin
        cmd_o.op = OP_NSTORE;
        comp_d   = comp_q + 2'd1;
        if (comp_q == 2'd2) begin
          if (load_q) begin
            state_d = S_WRITE;
          end else begin
            est_d   = ST_INTERP;
            state_d = S_EMIT;
          end
        end else begin
          state_d = S_NDIV0;
        end
      end
      S_WRITE: begin
        cmd_o.op = OP_WRITE;
        state_d  = S_IDLE;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/idwvf_dp.sv
module idwvf_dp #(
  parameter int unsigned MaxAnchors = idwvf_pkg::MAX_ANCHORS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  idwvf_pkg::dp_cmd_t  cmd_i,
  output idwvf_pkg::dp_stat_t stat_o,
  input  logic [1:0]          in_kind_i,
  input  logic [2:0][15:0]    in_pos_i,
  input  logic [2:0][15:0]    in_vec_i,
  input  logic                in_has_vector_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0][15:0]    out_vec_o,
  output logic [2:0]          out_status_o
);
  import idwvf_pkg::*;

  localparam int unsigned AW    = (MaxAnchors > 1) ? $clog2(MaxAnchors) : 1;
  localparam int unsigned CNT_W = $clog2(MaxAnchors + 1);
  localparam int unsigned RAM_W = 6 * VEC_W;

  logic [1:0]                    kind_q;
  logic                          hasv_q;
  logic [2:0][POS_W-1:0]         pos_q;
  logic [2:0][VEC_W-1:0]         vec_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [AW-1:0]                 idx_q;
  logic signed [POS_W:0]         d_q [3];
  logic [D2_W-1:0]               d2_q;
  logic signed [ACC_W-1:0]       s_q [3];
  logic [ACC_W-1:0]              m_q [3];
  logic [2:0]                    neg_q;
  logic [SQ_W-1:0]               sq_q;
  logic [SQ_W-1:0]               sn_q, sr_q, sb_q;
  logic [DIV_NUM_W-1:0]          num_q;
  logic [D2_W-1:0]               den_q;
  logic [D2_W-1:0]               rem_q;
  logic [2:0][VEC_W-1:0]         res_q;
  logic                          out_valid_q;
  logic [2:0][VEC_W-1:0]         out_vec_q;
  logic [2:0]                    out_status_q;

  logic [RAM_W-1:0]              ram_rdata;
  logic [2:0][VEC_W-1:0]         ram_u;
  logic [2:0][POS_W-1:0]         ram_p;

  logic [D2_W:0]                 rem_t, rem_n;
  logic                          div_ge;
  logic [SQ_W-1:0]               sq_sum;
  logic                          sq_ge;
  logic signed [2*POS_W+1:0]     d_sq;
  logic signed [W_W+VEC_W:0]     mac_prod;
  logic [2*(NORM_SH+1)-1:0]      m_sq;
  logic [NORM_SH:0]              m_c;
  logic [VEC_W-1:0]              q16;
  logic                          emit;

  idwvf_ram #(
    .Width (RAM_W),
    .Depth (MaxAnchors),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_WRITE),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({pos_q, res_q}),
    .re_i    (cmd_i.op == OP_RD),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign ram_u = ram_rdata[3*VEC_W-1:0];
  assign ram_p = ram_rdata[RAM_W-1:3*VEC_W];

  assign rem_t  = {rem_q, num_q[DIV_NUM_W-1]};
  assign div_ge = rem_t >= {1'b0, den_q};
  assign rem_n  = div_ge ? rem_t - {1'b0, den_q} : rem_t;

  assign sq_sum = sr_q + sb_q;
  assign sq_ge  = sn_q >= sq_sum;

  assign d_sq     = d_q[cmd_i.comp] * d_q[cmd_i.comp];
  assign mac_prod = $signed({1'b0, num_q[W_W-1:0]}) * $signed(ram_u[cmd_i.comp]);
  assign m_c      = m_q[cmd_i.comp][NORM_SH:0];
  assign m_sq     = m_c * m_c;
  assign q16      = num_q[VEC_W-1:0];
  assign emit     = (cmd_i.op == OP_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_CLEAR) begin
        cnt_q <= '0;
      end else if (cmd_i.op == OP_WRITE) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_vec_q    <= res_q;
      out_status_q <= cmd_i.status;
    end
    unique case (cmd_i.op)
      OP_LATCH: begin
        kind_q <= in_kind_i;
        hasv_q <= in_has_vector_i;
        pos_q  <= in_pos_i;
        vec_q  <= in_vec_i;
      end
      OP_QINIT: begin
        for (int i = 0; i < 3; i++) begin
          s_q[i] <= '0;
        end
        idx_q <= '0;
      end
      OP_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          d_q[i] <= $signed({pos_q[i][POS_W-1], pos_q[i]})
                  - $signed({ram_p[i][POS_W-1], ram_p[i]});
        end
        d2_q <= '0;
      end
      OP_SQD: begin
        d2_q <= d2_q + D2_W'(unsigned'(d_sq));
      end
      OP_WDIV_INIT: begin
        num_q <= DIV_NUM_W'(1) << (W_W - 1);
        den_q <= d2_q;
        rem_q <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= rem_n[D2_W-1:0];
        num_q <= {num_q[DIV_NUM_W-2:0], div_ge};
      end
      OP_MAC: begin
        s_q[cmd_i.comp] <= s_q[cmd_i.comp] + ACC_W'(mac_prod);
      end
      OP_NEXT: begin
        idx_q <= idx_q + 1'b1;
      end
      OP_SVEC: begin
        for (int i = 0; i < 3; i++) begin
          s_q[i] <= ACC_W'($signed(vec_q[i]));
        end
      end
      OP_ABS: begin
        for (int i = 0; i < 3; i++) begin
          m_q[i]   <= s_q[i][ACC_W-1] ? ACC_W'(-s_q[i]) : ACC_W'(s_q[i]);
          neg_q[i] <= s_q[i][ACC_W-1];
        end
        sq_q <= '0;
      end
      OP_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          m_q[i] <= m_q[i] >> 1;
        end
      end
      OP_SQN: begin
        sq_q <= sq_q + SQ_W'(m_sq);
      end
      OP_SQRT_INIT: begin
        sn_q <= sq_q;
        sr_q <= '0;
        sb_q <= SQ_W'(1) << (SQ_W - 2);
      end
      OP_SQRT_STEP: begin
        if (sq_ge) begin
          sn_q <= sn_q - sq_sum;
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
      end
      OP_NDIV_INIT: begin
        num_q <= {m_c, {FRAC_W{1'b0}}} + DIV_NUM_W'(sr_q >> 1);
        den_q <= D2_W'(sr_q);
        rem_q <= '0;
      end
      OP_NSTORE: begin
        res_q[cmd_i.comp] <= neg_q[cmd_i.comp] ? -q16 : q16;
      end
      OP_COPY: begin
        res_q <= ram_u;
      end
      OP_PASS: begin
        res_q <= vec_q;
      end
      OP_RES_ZERO: begin
        res_q <= '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat_o.kind       = kind_q;
    stat_o.has_vector = hasv_q;
    stat_o.cnt_zero   = (cnt_q == '0);
    stat_o.cnt_full   = (cnt_q == CNT_W'(MaxAnchors));
    stat_o.d2_zero    = (d2_q == '0);
    stat_o.idx_last   = ((CNT_W'(idx_q) + 1'b1) == cnt_q);
    stat_o.m_zero     = (m_q[0] == '0) && (m_q[1] == '0) && (m_q[2] == '0);
    stat_o.m_big      = (m_q[0] > (ACC_W'(1) << NORM_SH))
                     || (m_q[1] > (ACC_W'(1) << NORM_SH))
                     || (m_q[2] > (ACC_W'(1) << NORM_SH));
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_vec_o    = out_vec_q;
  assign out_status_o = out_status_q;

endmodule

### dv/idw_vector_field_interpolator_unit_tb.sv
module idw_vector_field_interpolator_unit_tb;
  import idwvf_pkg::*;

  localparam int unsigned NUM_ITEMS = 900;
  localparam int unsigned CALM_FROM = 800;
  localparam int unsigned SETTLE    = 400;
  localparam logic [1:0]  KIND_RSVD = 2'd3;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] px, py, pz;
    logic signed [15:0] vx, vy, vz;
    logic               hv;
  } xact_t;

  typedef struct {
    logic signed [15:0] x, y, z;
    status_e            st;
  } field_res_t;

  typedef struct {
    xact_t      it;
    bit         typed;
    field_res_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  idwvf_in_if  in_if ();
  idwvf_out_if out_if ();

  idw_vector_field_interpolator_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic signed [15:0] anc_pos[MAX_ANCHORS_DEF][3];
  logic signed [15:0] anc_uvec[MAX_ANCHORS_DEF][3];
  int unsigned        anc_cnt;

  field_res_t vec_expect_q[$];
  int unsigned n_err;
  int unsigned n_sent;
  bit          calm;

  function automatic bit unit_vec(input longint s[3], output logic signed [15:0] o[3]);
    longint unsigned m[3];
    longint unsigned mx, sq, len, t, q;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (s[i] < 0) ? longint'(-s[i]) : s[i];
      if (m[i] > mx) mx = m[i];
      o[i] = '0;
    end
    if (mx == 0) return 1'b0;
    while (mx > (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = 0;
    for (int b = 31; b >= 0; b--) begin
      t = len | (64'd1 << b);
      if (t * t <= sq) len = t;
    end
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 4096 + len / 2) / len;
      o[i] = (s[i] < 0) ? -16'(q) : 16'(q);
    end
    return 1'b1;
  endfunction

  function automatic bit predict_field(input xact_t it, output field_res_t r);
    longint s[3];
    logic signed [15:0] u[3];
    logic signed [15:0] p[3];
    longint d, d2, w;
    bit nz;
    r.x = '0; r.y = '0; r.z = '0; r.st = ST_INTERP;
    p[0] = it.px; p[1] = it.py; p[2] = it.pz;
    case (it.kind)
      KIND_LOAD: begin
        if (anc_cnt >= MAX_ANCHORS_DEF) begin
          r.st = ST_FULL;
          return 1'b1;
        end
        s[0] = it.vx; s[1] = it.vy; s[2] = it.vz;
        nz = unit_vec(s, u);
        for (int i = 0; i < 3; i++) begin
          anc_uvec[anc_cnt][i] = u[i];
          anc_pos[anc_cnt][i] = p[i];
        end
        anc_cnt++;
        return 1'b0;
      end
      KIND_CLEAR: begin
        anc_cnt = 0;
        return 1'b0;
      end
      KIND_QUERY: begin
        if (it.hv) begin
          r.x = it.vx; r.y = it.vy; r.z = it.vz; r.st = ST_PASS;
          return 1'b1;
        end
        if (anc_cnt == 0) begin
          r.st = ST_DEGEN;
          return 1'b1;
        end
        s = '{0, 0, 0};
        for (int k = 0; k < anc_cnt; k++) begin
          d2 = 0;
          for (int i = 0; i < 3; i++) begin
            d = longint'(p[i]) - longint'(anc_pos[k][i]);
            d2 += d * d;
          end
          if (d2 == 0) begin
            r.x = anc_uvec[k][0]; r.y = anc_uvec[k][1]; r.z = anc_uvec[k][2];
            r.st = ST_EXACT;
            return 1'b1;
          end
          w = (longint'(1) << 38) / d2;
          for (int i = 0; i < 3; i++) s[i] += w * longint'(anc_uvec[k][i]);
        end
        nz = unit_vec(s, u);
        r.x = u[0]; r.y = u[1]; r.z = u[2];
        r.st = nz ? ST_INTERP : ST_DEGEN;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send(input xact_t it, input bit typed = 1'b0,
                      input field_res_t tres = '{0, 0, 0, ST_INTERP});
    field_res_t r;
    field_res_t e;
    int unsigned gap;
    if (!calm && ($urandom % 6 == 0)) begin
      gap = $urandom_range(1, 19);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= it.kind;
    in_if.pos_x      <= it.px;
    in_if.pos_y      <= it.py;
    in_if.pos_z      <= it.pz;
    in_if.vec_in_x   <= it.vx;
    in_if.vec_in_y   <= it.vy;
    in_if.vec_in_z   <= it.vz;
    in_if.has_vector <= it.hv;
    do @(posedge clk_i); while (!in_if.ready);
    if (predict_field(it, r)) begin
      e = typed ? tres : r;
      vec_expect_q = {vec_expect_q, e};
    end
    n_sent++;
    calm = (n_sent >= CALM_FROM);
  endtask

  function automatic xact_t mk(logic [1:0] k, int px, int py, int pz,
                               int vx, int vy, int vz, bit hv);
    xact_t t;
    t.kind = k; t.px = 16'(px); t.py = 16'(py); t.pz = 16'(pz);
    t.vx = 16'(vx); t.vy = 16'(vy); t.vz = 16'(vz); t.hv = hv;
    return t;
  endfunction

  function automatic xact_t rand_xact(logic [1:0] k, bit near);
    xact_t t;
    t.kind = k;
    if (near) begin
      t.px = 16'(int'($urandom_range(0, 16)) - 8);
      t.py = 16'(int'($urandom_range(0, 16)) - 8);
      t.pz = 16'(int'($urandom_range(0, 16)) - 8);
    end else begin
      t.px = 16'($urandom); t.py = 16'($urandom); t.pz = 16'($urandom);
    end
    if ($urandom % 12 == 0) begin
      t.vx = '0; t.vy = '0; t.vz = '0;
    end else begin
      t.vx = 16'($urandom); t.vy = 16'($urandom); t.vz = 16'($urandom);
    end
    t.hv = 1'($urandom);
    return t;
  endfunction

  // response side: random stalls, checks in order
  int unsigned stall_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (vec_expect_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result %0d %0d %0d status %0d",
                                    out_if.vec_out_x, out_if.vec_out_y,
                                    out_if.vec_out_z, out_if.status);
        end else begin
          field_res_t e;
          e = vec_expect_q.pop_front();
          if (out_if.vec_out_x !== e.x || out_if.vec_out_y !== e.y ||
              out_if.vec_out_z !== e.z || out_if.status !== e.st) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: exp %0d %0d %0d st %0d, got %0d %0d %0d st %0d",
                       e.x, e.y, e.z, e.st, out_if.vec_out_x, out_if.vec_out_y,
                       out_if.vec_out_z, out_if.status);
          end
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        out_if.ready <= 1'b0;
      end else if (!calm && ($urandom % 8 == 0)) begin
        stall_cnt <= $urandom_range(1, 19) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #200000000;
    $display("idw_vector_field_interpolator_unit_tb: errors");
    $finish;
  end

  initial begin
    row_t        rows[$];
    row_t        rw;
    xact_t       it;
    xact_t       stored[$];
    int unsigned n_load, n_qry, pick;
    bit          near;

    n_err = 0; n_sent = 0; calm = 1'b0; anc_cnt = 0;
    in_if.valid = 1'b0; in_if.kind = KIND_LOAD;
    in_if.pos_x = '0; in_if.pos_y = '0; in_if.pos_z = '0;
    in_if.vec_in_x = '0; in_if.vec_in_y = '0; in_if.vec_in_z = '0;
    in_if.has_vector = 1'b0;

    rw.typed = 1'b1;
    rw.it = mk(KIND_QUERY, 1, 2, 3, 0, 0, 0, 0);             rw.res = '{0, 0, 0, ST_DEGEN};
    rows = {rows, rw};
    rw.it = mk(KIND_QUERY, 9, 9, 9, -32768, 32767, 0, 1);     rw.res = '{-32768, 32767, 0, ST_PASS};
    rows = {rows, rw};
    rw.typed = 1'b0;
    rw.it = mk(KIND_RSVD, 0, 0, 0, 100, 0, 0, 0);             rows = {rows, rw};
    rw.it = mk(KIND_LOAD, 0, 0, 0, 4096, 0, 0, 0);            rows = {rows, rw};
    rw.it = mk(KIND_LOAD, -32768, -32768, -32768, -32768, -32768, -32768, 0);
    rows = {rows, rw};
    rw.it = mk(KIND_LOAD, 32767, 32767, 32767, 32767, -1, 1, 0); rows = {rows, rw};
    rw.it = mk(KIND_LOAD, 5, 5, 5, 0, 0, 0, 0);               rows = {rows, rw};
    rw.it = mk(KIND_LOAD, 0, 0, 0, 0, 4096, 0, 0);            rows = {rows, rw};
    rw.it = mk(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0);              rows = {rows, rw};
    rw.it = mk(KIND_QUERY, 5, 5, 5, 0, 0, 0, 0);              rows = {rows, rw};
    rw.it = mk(KIND_QUERY, 32767, -32768, 0, 0, 0, 0, 0);     rows = {rows, rw};
    rw.it = mk(KIND_QUERY, 1, 0, 0, 0, 0, 0, 0);              rows = {rows, rw};
    rw.it = mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);              rows = {rows, rw};
    rw.typed = 1'b1;
    rw.it = mk(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0);              rw.res = '{0, 0, 0, ST_DEGEN};
    rows = {rows, rw};
    rw.typed = 1'b0;
    rw.it = mk(KIND_LOAD, 1, 0, 0, 4096, 0, 0, 0);            rows = {rows, rw};
    rw.it = mk(KIND_LOAD, -1, 0, 0, -4096, 0, 0, 0);          rows = {rows, rw};
    rw.typed = 1'b1;
    rw.it = mk(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0);              rw.res = '{0, 0, 0, ST_DEGEN};
    rows = {rows, rw};
    rw.typed = 1'b0;
    rw.it = mk(KIND_QUERY, 0, 7, 0, 0, 0, 0, 0);              rows = {rows, rw};
    rw.it = mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);              rows = {rows, rw};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].res);

    // fill the store, then overflow it
    for (int i = 0; i < MAX_ANCHORS_DEF; i++) send(rand_xact(KIND_LOAD, i[0]));
    rw.res = '{0, 0, 0, ST_FULL};
    send(mk(KIND_LOAD, 3, 3, 3, 4096, 0, 0, 0), 1'b1, rw.res);
    send(mk(KIND_LOAD, -32768, 32767, 0, -32768, 32767, -1, 1), 1'b1, rw.res);
    it = rand_xact(KIND_QUERY, 1'b1); it.hv = 1'b0;
    send(it);
    send(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));

    while (n_sent < NUM_ITEMS) begin
      if ($urandom % 8 != 0) begin
        send(rand_xact(KIND_CLEAR, 1'b0));
        stored.delete();
      end
      near = 1'($urandom % 2);
      n_load = ($urandom % 10 == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      for (int i = 0; i < n_load; i++) begin
        it = rand_xact(KIND_LOAD, near);
        send(it);
        stored = {stored, it};
      end
      n_qry = $urandom_range(1, 6);
      for (int i = 0; i < n_qry; i++) begin
        pick = $urandom % 10;
        it = rand_xact(KIND_QUERY, near);
        it.hv = (pick < 2);
        if (pick >= 2 && pick < 4 && stored.size() > 0) begin
          rw.it = stored[$urandom % stored.size()];
          it.px = rw.it.px; it.py = rw.it.py; it.pz = rw.it.pz;
        end else if (pick == 4) begin
          it.kind = KIND_RSVD;
        end
        send(it);
      end
    end

    in_if.valid <= 1'b0;
    while (vec_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (n_err == 0) begin
      $display("idw_vector_field_interpolator_unit_tb: clean");
    end else begin
      $display("idw_vector_field_interpolator_unit_tb: errors");
    end
    $finish;
  end

endmodule
